// ===== rtl/dbch_pkg.sv =====
// Package: shared types and constants of the double-byte character histogram.
`default_nettype none

package dbch_pkg;

    // Histogram geometry
    localparam int HIGH_ROWS      = 72;
    localparam int LOW_COLS       = 94;
    localparam int MAX_LINE_BYTES = 967;
    localparam int BIN_TOTAL      = HIGH_ROWS * LOW_COLS;

    // Byte ranges and count limit
    localparam int HIGH_BASE = 176;
    localparam int LOW_BASE  = 161;
    localparam int COUNT_MAX = 255;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int BIN_W   = 13;
    localparam int COUNT_W = 8;
    localparam int LINE_W  = 10;

    // Word kinds
    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] text_byte;
        logic [BIN_W-1:0]  bin_index;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [BIN_W-1:0]   bin_echo;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/double_byte_char_histogram.sv =====
// Top level: double-byte character histogram with its bin memory and control.
//
//  Channel  Direction  Handshake            Word
//  -------  ---------  -------------------  ----------------------------------------
//  in       input      in_valid / in_ready  dbch_pkg::in_word_t (kind, byte, index)
//  out      output     out_valid/out_ready  dbch_pkg::out_word_t (count, echo)
//
//  A text byte that closes a candidate pair needs a bin memory read, then the
//  increment and write back unless the bin is full. Other text bytes and end
//  of line need neither. A bin read waits in ST_READ while the output register
//  stays full. After reset the bin memory is zeroed one entry a cycle, with
//  in_ready low throughout. The output register lets the next word in while a
//  result still waits on out_ready.
`default_nettype none

module double_byte_char_histogram (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dbch_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dbch_pkg::out_word_t      out_data
);

    // Control states
    localparam logic [1:0] ST_CLEAR = 2'd0;   // zeroing pass after reset
    localparam logic [1:0] ST_IDLE  = 2'd1;   // take the next word
    localparam logic [1:0] ST_PAIR  = 2'd2;   // bin count of a pair is back
    localparam logic [1:0] ST_READ  = 2'd3;   // bin count of a read is back

    localparam logic [dbch_pkg::BIN_W-1:0] LAST_BIN = dbch_pkg::BIN_W'(dbch_pkg::BIN_TOTAL - 1);

    // Bin memory
    logic [dbch_pkg::COUNT_W-1:0] bin_mem [0:dbch_pkg::BIN_TOTAL-1];
    logic [dbch_pkg::COUNT_W-1:0] rd_data_reg;
    logic                         mem_we;
    logic [dbch_pkg::BIN_W-1:0]   mem_waddr;
    logic [dbch_pkg::COUNT_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [dbch_pkg::BIN_W-1:0]   mem_raddr;

    // Control and line state
    logic [1:0]                   state_reg, state_next;
    logic [dbch_pkg::BIN_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [dbch_pkg::BYTE_W-1:0]  pending_byte_reg, pending_byte_next;
    logic                         pending_valid_reg, pending_valid_next;
    logic [dbch_pkg::LINE_W-1:0]  line_cnt_reg, line_cnt_next;

    // Work in flight
    logic [dbch_pkg::BIN_W-1:0]   bin_addr_reg, bin_addr_next;
    logic [dbch_pkg::BYTE_W-1:0]  hold_byte_reg, hold_byte_next;
    logic                         rd_clear_reg, rd_clear_next;
    logic                         rd_in_range_reg, rd_in_range_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_load;
    logic [dbch_pkg::COUNT_W-1:0] out_count_reg;
    logic [dbch_pkg::BIN_W-1:0]   out_echo_reg;

    // Pair decode of pending byte and incoming byte
    logic [dbch_pkg::BYTE_W-1:0]  row_diff;
    logic [dbch_pkg::BYTE_W-1:0]  col_diff;
    logic [dbch_pkg::BIN_W-1:0]   pair_bin;
    logic                         high_ok;
    logic                         low_ok;
    logic                         line_full;
    logic                         idx_in_range;

    always_comb
    begin
        high_ok = (pending_byte_reg >= dbch_pkg::BYTE_W'(dbch_pkg::HIGH_BASE)) &&
                  (pending_byte_reg <  dbch_pkg::BYTE_W'(dbch_pkg::HIGH_BASE
                                                          + dbch_pkg::HIGH_ROWS));
        low_ok  = (in_data.text_byte >= dbch_pkg::BYTE_W'(dbch_pkg::LOW_BASE)) &&
                  ({1'b0, in_data.text_byte} <
                   9'(dbch_pkg::LOW_BASE + dbch_pkg::LOW_COLS));
        row_diff = pending_byte_reg - dbch_pkg::BYTE_W'(dbch_pkg::HIGH_BASE);
        col_diff = in_data.text_byte - dbch_pkg::BYTE_W'(dbch_pkg::LOW_BASE);
        pair_bin = dbch_pkg::BIN_W'(row_diff[6:0]) * dbch_pkg::BIN_W'(dbch_pkg::LOW_COLS)
                 + dbch_pkg::BIN_W'(col_diff[6:0]);
        line_full    = line_cnt_reg >= dbch_pkg::LINE_W'(dbch_pkg::MAX_LINE_BYTES);
        idx_in_range = in_data.bin_index < dbch_pkg::BIN_W'(dbch_pkg::BIN_TOTAL);
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        clr_addr_next      = clr_addr_reg;
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        line_cnt_next      = line_cnt_reg;
        bin_addr_next      = bin_addr_reg;
        hold_byte_next     = hold_byte_reg;
        rd_clear_next      = rd_clear_reg;
        rd_in_range_next   = rd_in_range_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_load           = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = bin_addr_reg;
        mem_wdata          = '0;
        mem_re             = 1'b0;
        mem_raddr          = in_data.bin_index;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one bin a cycle
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_BIN)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.kind)
                        dbch_pkg::KIND_TEXT:
                        begin
                            if (!line_full)
                            begin
                                line_cnt_next = line_cnt_reg + 1'b1;
                                if (pending_valid_reg && high_ok && low_ok)
                                begin
                                    // Fetch the pair's bin; decide next cycle
                                    mem_re         = 1'b1;
                                    mem_raddr      = pair_bin;
                                    bin_addr_next  = pair_bin;
                                    hold_byte_next = in_data.text_byte;
                                    state_next     = ST_PAIR;
                                end
                                else
                                begin
                                    pending_byte_next  = in_data.text_byte;
                                    pending_valid_next = 1'b1;
                                end
                            end
                        end
                        dbch_pkg::KIND_EOL:
                        begin
                            pending_byte_next  = '0;
                            pending_valid_next = 1'b0;
                            line_cnt_next      = '0;
                        end
                        dbch_pkg::KIND_READ, dbch_pkg::KIND_CLEAR:
                        begin
                            mem_re           = idx_in_range;
                            mem_raddr        = in_data.bin_index;
                            bin_addr_next    = in_data.bin_index;
                            rd_clear_next    = (in_data.kind == dbch_pkg::KIND_CLEAR);
                            rd_in_range_next = idx_in_range;
                            state_next       = ST_READ;
                        end
                    endcase
                end
            end
            ST_PAIR:
            begin
                if (rd_data_reg != dbch_pkg::COUNT_W'(dbch_pkg::COUNT_MAX))
                begin
                    // Count the pair and consume both bytes
                    mem_we             = 1'b1;
                    mem_wdata          = rd_data_reg + 1'b1;
                    pending_byte_next  = '0;
                    pending_valid_next = 1'b0;
                end
                else
                begin
                    // Saturated: low byte becomes the next candidate
                    pending_byte_next  = hold_byte_reg;
                    pending_valid_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    mem_we         = rd_clear_reg && rd_in_range_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            pending_byte_reg  <= '0;
            pending_valid_reg <= 1'b0;
            line_cnt_reg      <= '0;
            rd_clear_reg      <= 1'b0;
            rd_in_range_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_addr_reg      <= clr_addr_next;
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            line_cnt_reg      <= line_cnt_next;
            rd_clear_reg      <= rd_clear_next;
            rd_in_range_reg   <= rd_in_range_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_addr_reg  <= bin_addr_next;
        hold_byte_reg <= hold_byte_next;
        if (out_load)
        begin
            out_count_reg <= rd_in_range_reg ? rd_data_reg : '0;
            out_echo_reg  <= bin_addr_reg;
        end
    end

    // Bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= bin_mem[mem_raddr];
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data.bin_count = out_count_reg;
    assign out_data.bin_echo  = out_echo_reg;

`ifndef SYNTHESIS
    // Reads and writes of the bin memory never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("bin memory read and write in the same cycle");

    // A result appears only after a bin read comes back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result loaded outside the read state");

    // A counted pair leaves no pending byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) && (rd_data_reg != dbch_pkg::COUNT_W'(dbch_pkg::COUNT_MAX))
        |=> !pending_valid_reg)
        else $error("pending byte kept after a counted pair");

    // The line byte count stops at the line limit
    assert property (@(posedge clk) disable iff (!rst_n)
        line_cnt_reg <= dbch_pkg::LINE_W'(dbch_pkg::MAX_LINE_BYTES))
        else $error("line byte count past the line limit");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/double_byte_char_histogram_tb.sv =====
// Testbench for the double-byte character histogram: directed table, random lines, checker.
`timescale 1ns / 1ps

module double_byte_char_histogram_tb;
    import dbch_pkg::*;

    // Handshake pressure, stepped through as the run advances
    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SRC_GAPS,
        TRAFFIC_SINK_STALLS,
        TRAFFIC_BOTH
    } traffic_mode_t;

    // One row of the directed table; typed rows carry the count to expect
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  text_byte;
        logic [BIN_W-1:0]   bin_index;
        bit                 typed;
        logic [COUNT_W-1:0] count;
    } stim_row_t;

    localparam int DIRECTED_ROWS  = 27;
    localparam int HOT_BINS       = 6;
    localparam int RANDOM_WORDS   = 100;
    localparam int WORDS_PER_MODE = 120;
    localparam int INDEX_TOP      = (1 << BIN_W) - 1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    double_byte_char_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted block state: bin counts (zero after reset), the byte held as a
    // candidate high byte, and the number of text bytes taken on this line.
    bit [COUNT_W-1:0] char_counts [BIN_TOTAL];
    bit [BYTE_W-1:0]  held_byte;
    bit               held_valid;
    bit [LINE_W-1:0]  line_bytes;
    bit               byte_dropped;

    // Read results still owed by the block, oldest first
    out_word_t pending_reads [$];

    traffic_mode_t traffic = TRAFFIC_STEADY;
    int unsigned   hot_bins [HOT_BINS];
    stim_row_t     directed [DIRECTED_ROWS];

    int words_sent;
    int counted_words;
    int results_seen;
    int pairs_counted;
    int saturated_pairs;
    int bytes_dropped;
    int fail_count;

    // Advance the predicted state by one word; return 1 when the word yields
    // a read result, placed in r.
    function automatic bit tally_word(input in_word_t w, output out_word_t r);
        int hb;
        int lb;
        int bin;
        hb = int'(held_byte);
        lb = int'(w.text_byte);
        r = '0;
        byte_dropped = 1'b0;
        case (w.kind)
            KIND_TEXT:
            begin
                // Drop bytes once the line has reached its limit
                if (int'(line_bytes) >= MAX_LINE_BYTES)
                begin
                    byte_dropped = 1'b1;
                    bytes_dropped++;
                    return 1'b0;
                end
                line_bytes = line_bytes + 1'b1;
                if (held_valid && hb >= HIGH_BASE && hb < HIGH_BASE + HIGH_ROWS &&
                    lb >= LOW_BASE && lb < LOW_BASE + LOW_COLS)
                begin
                    bin = (hb - HIGH_BASE) * LOW_COLS + (lb - LOW_BASE);
                    if (int'(char_counts[bin]) < COUNT_MAX)
                    begin
                        // A counted pair consumes both bytes
                        char_counts[bin] = char_counts[bin] + 1'b1;
                        held_valid = 1'b0;
                        held_byte = '0;
                        pairs_counted++;
                        return 1'b0;
                    end
                    saturated_pairs++;
                end
                // Hold the later byte as the next candidate high byte
                held_byte = w.text_byte;
                held_valid = 1'b1;
                return 1'b0;
            end
            KIND_EOL:
            begin
                held_byte = '0;
                held_valid = 1'b0;
                line_bytes = '0;
                return 1'b0;
            end
            KIND_READ, KIND_CLEAR:
            begin
                // Out-of-range bins answer zero and are never cleared
                r.bin_echo = w.bin_index;
                if (int'(w.bin_index) < BIN_TOTAL)
                begin
                    r.bin_count = char_counts[w.bin_index];
                    if (w.kind == KIND_CLEAR)
                        char_counts[w.bin_index] = '0;
                end
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Drive one word and wait for its acceptance. Valid stays high from one
    // word to the next unless a source gap is drawn; a typed count replaces
    // the predicted one.
    task automatic send_word(input logic [KIND_W-1:0] kind, input int unsigned b,
                             input int unsigned idx, input bit typed = 1'b0,
                             input logic [COUNT_W-1:0] typed_count = '0);
        in_word_t  w;
        out_word_t r;
        int        gap_pct;
        w.kind = kind;
        w.text_byte = b[BYTE_W-1:0];
        w.bin_index = idx[BIN_W-1:0];
        traffic = traffic_mode_t'((words_sent / WORDS_PER_MODE) % 4);
        gap_pct = (traffic == TRAFFIC_SRC_GAPS) ? 46 : (traffic == TRAFFIC_BOTH) ? 31 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        words_sent++;
        if (tally_word(w, r))
        begin
            if (typed)
                r.bin_count = typed_count;
            pending_reads.push_back(r);
        end
        if (!byte_dropped)
            counted_words++;
    endtask

    // Mostly a handful of hot bins so counts build up, else any valid bin
    function automatic int unsigned pick_bin();
        if ($urandom_range(99) < 75)
            return hot_bins[$urandom_range(HOT_BINS - 1)];
        return $urandom_range(BIN_TOTAL - 1);
    endfunction

    // Bin to read: usually a real bin, sometimes past the end of the table
    function automatic int unsigned pick_index();
        if ($urandom_range(99) < 90)
            return pick_bin();
        return $urandom_range(INDEX_TOP, BIN_TOTAL);
    endfunction

    task automatic send_pair(input int unsigned bin);
        send_word(KIND_TEXT, HIGH_BASE + bin / LOW_COLS, $urandom_range(INDEX_TOP));
        send_word(KIND_TEXT, LOW_BASE + bin % LOW_COLS, $urandom_range(INDEX_TOP));
    endtask

    // Sink side: hold ready high, or stall at random in the stall modes
    always @(posedge clk)
    begin
        case (traffic)
            TRAFFIC_SINK_STALLS: out_ready <= ($urandom_range(99) >= 46);
            TRAFFIC_BOTH:        out_ready <= ($urandom_range(99) >= 31);
            default:             out_ready <= 1'b1;
        endcase
    end

    // Checker: every accepted result against the oldest owed read
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (pending_reads.size() == 0)
            begin
                $error("unexpected result: bin_count %0d bin_echo %0d",
                       out_data.bin_count, out_data.bin_echo);
                fail_count++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (out_data.bin_count !== want.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d", want.bin_count,
                           out_data.bin_count);
                    fail_count++;
                end
                if (out_data.bin_echo !== want.bin_echo)
                begin
                    $error("bin_echo: expected %0d, got %0d", want.bin_echo,
                           out_data.bin_echo);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned bin;
        int          sel;
        int          len;
        int          target;
        int          mark;
        bit          long_done;

        // Directed table. Typed rows: reads right after reset, the table edges,
        // and reads past the end; the rest go through the predictor.
        directed = '{
            '{KIND_READ,  8'd0,   13'd0,    1'b1, 8'd0},  // fresh after reset
            '{KIND_READ,  8'd0,   13'd6767, 1'b1, 8'd0},  // last bin
            '{KIND_CLEAR, 8'd0,   13'd6768, 1'b1, 8'd0},  // clear past the end
            '{KIND_READ,  8'd255, 13'd8191, 1'b1, 8'd0},  // widest index
            '{KIND_TEXT,  8'd176, 13'd0,    1'b0, 8'd0},  // lowest pair
            '{KIND_TEXT,  8'd161, 13'd0,    1'b0, 8'd0},
            '{KIND_READ,  8'd0,   13'd0,    1'b1, 8'd1},
            '{KIND_TEXT,  8'd247, 13'd0,    1'b0, 8'd0},  // highest pair
            '{KIND_TEXT,  8'd254, 13'd0,    1'b0, 8'd0},
            '{KIND_CLEAR, 8'd0,   13'd6767, 1'b1, 8'd1},
            '{KIND_READ,  8'd0,   13'd6767, 1'b1, 8'd0},  // cleared
            '{KIND_TEXT,  8'd175, 13'd0,    1'b0, 8'd0},  // just below high range
            '{KIND_TEXT,  8'd248, 13'd0,    1'b0, 8'd0},  // just above high range
            '{KIND_TEXT,  8'd161, 13'd0,    1'b0, 8'd0},  // no pair, held
            '{KIND_TEXT,  8'd176, 13'd0,    1'b0, 8'd0},
            '{KIND_TEXT,  8'd160, 13'd0,    1'b0, 8'd0},  // just below low range
            '{KIND_TEXT,  8'd177, 13'd0,    1'b0, 8'd0},
            '{KIND_EOL,   8'd0,   13'd0,    1'b0, 8'd0},  // drops the held 177
            '{KIND_TEXT,  8'd161, 13'd0,    1'b0, 8'd0},
            '{KIND_TEXT,  8'd177, 13'd0,    1'b0, 8'd0},
            '{KIND_READ,  8'd0,   13'd0,    1'b1, 8'd1},  // read inside a line
            '{KIND_TEXT,  8'd255, 13'd0,    1'b0, 8'd0},  // just above low range
            '{KIND_TEXT,  8'd0,   13'd0,    1'b0, 8'd0},
            '{KIND_TEXT,  8'd200, 13'd0,    1'b0, 8'd0},
            '{KIND_TEXT,  8'd200, 13'd0,    1'b0, 8'd0},  // byte in both ranges
            '{KIND_READ,  8'd0,   13'd2295, 1'b0, 8'd0},
            '{KIND_EOL,   8'd0,   13'd0,    1'b0, 8'd0}
        };

        hot_bins[0] = 0;
        hot_bins[1] = BIN_TOTAL - 1;
        for (int i = 2; i < HOT_BINS; i++)
            hot_bins[i] = $urandom_range(BIN_TOTAL - 1);

        // Hold reset at the start, once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].kind, 32'(directed[i].text_byte),
                      32'(directed[i].bin_index), directed[i].typed, directed[i].count);

        // Random lines. The long line is extra to the random budget.
        long_done = 1'b0;
        target = counted_words + RANDOM_WORDS;
        mark = counted_words;
        while (counted_words < target)
        begin
            if (!long_done && counted_words - mark > 40)
            begin
                // One long line: saturate a bin and keep pairing into it, fill
                // the rest with random bytes and reads, and let the last pair
                // straddle the limit so its low byte and the bytes after it
                // are dropped.
                long_done = 1'b1;
                mark = counted_words;
                bin = pick_bin();
                send_word(KIND_EOL, $urandom_range(255), $urandom_range(INDEX_TOP));
                send_word(KIND_CLEAR, $urandom_range(255), bin);
                repeat (COUNT_MAX + 3) send_pair(bin);
                send_word(KIND_READ, $urandom_range(255), bin);
                while (int'(line_bytes) < MAX_LINE_BYTES - 3)
                begin
                    if ($urandom_range(99) < 8)
                        send_word(($urandom_range(99) < 25) ? KIND_CLEAR : KIND_READ,
                                  $urandom_range(255), pick_index());
                    else
                        send_word(KIND_TEXT, $urandom_range(255), $urandom_range(INDEX_TOP));
                end
                send_pair(bin);
                send_pair(pick_bin());
                repeat (6) send_word(KIND_TEXT, $urandom_range(255), $urandom_range(INDEX_TOP));
                send_word(KIND_READ, $urandom_range(255), bin);
                send_word(KIND_EOL, $urandom_range(255), $urandom_range(INDEX_TOP));
                send_pair(bin);
                send_word(KIND_READ, $urandom_range(255), bin);
                target += counted_words - mark;
                mark = counted_words;
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                begin
                    // Well-formed line with random content
                    len = $urandom_range(24, 1);
                    repeat (len)
                    begin
                        sel = $urandom_range(99);
                        if (sel < 55)
                            send_pair(pick_bin());
                        else if (sel < 65)
                            send_word(KIND_TEXT, HIGH_BASE + $urandom_range(HIGH_ROWS - 1),
                                      $urandom_range(INDEX_TOP));
                        else if (sel < 77)
                            send_word(KIND_TEXT, $urandom_range(255), $urandom_range(INDEX_TOP));
                        else if (sel < 95)
                            send_word(($urandom_range(99) < 25) ? KIND_CLEAR : KIND_READ,
                                      $urandom_range(255), pick_index());
                        else
                            send_word(KIND_EOL, $urandom_range(255), $urandom_range(INDEX_TOP));
                    end
                    if ($urandom_range(99) < 85)
                        send_word(KIND_EOL, $urandom_range(255), $urandom_range(INDEX_TOP));
                end
                else if (sel < 85)
                begin
                    // Noise: any kind, any field value
                    repeat ($urandom_range(16, 1))
                        send_word(KIND_W'($urandom_range(3)), $urandom_range(255),
                                  $urandom_range(INDEX_TOP));
                end
                else
                begin
                    // Burst of reads and clears, mostly of the hot bins, some past the table end
                    repeat ($urandom_range(8, 1))
                        send_word(($urandom_range(99) < 25) ? KIND_CLEAR : KIND_READ,
                                  $urandom_range(255), pick_index());
                end
            end
        end
        in_valid <= 1'b0;

        // Drain owed reads, then let the last text word settle
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d words, %0d read results checked", words_sent, results_seen);
        $display("pairs counted %0d, pairs into full bins %0d, bytes past line limit %0d",
                 pairs_counted, saturated_pairs, bytes_dropped);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== double_byte_char_histogram.f =====
rtl/dbch_pkg.sv
rtl/double_byte_char_histogram.sv
tb/sv/double_byte_char_histogram_tb.sv
